// ----- sv/ptht_pkg.sv -----
// shared types and constants for the page translation hash table
`default_nettype none
package ptht_pkg;

  localparam int LOG_SLOTS_DEF = 8;
  localparam int PAGE_W        = 20;
  localparam int FRAME_W       = 20;
  localparam int OCC_W         = 9;
  localparam int HASH_W        = 32;
  localparam logic [HASH_W-1:0] HASH_MULT = 32'd2654435761;

  // result codes
  typedef enum logic [1:0] {
    ST_MISS     = 2'd0,
    ST_HIT      = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // item modes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    load_home;
    logic    clr_wr;
    logic    rd_en;
    logic    probe_next;
    logic    ins_wr;
    logic    res_load;
    status_t res_status;
  } ptht_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_insert;
    logic slot_valid;
    logic page_match;
    logic last_probe;
    logic table_full;
    logic clr_done;
    logic out_free;
  } ptht_sts_t;

endpackage
`default_nettype wire

// ----- sv/ptht_dpath.sv -----
// datapath: hash, slot memory, probe index, entry count and result register
`default_nettype none
module ptht_dpath
  import ptht_pkg::*;
#(
  parameter int LOG_SLOTS = LOG_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ptht_cmd_t          cmd,
  output ptht_sts_t               sts,
  input  wire logic               in_mode,
  input  wire logic [PAGE_W-1:0]  in_page,
  input  wire logic [FRAME_W-1:0] in_frame,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output status_t                 out_status,
  output logic [FRAME_W-1:0]      out_frame,
  output logic [OCC_W-1:0]        out_occ
);

  localparam int CNT_W = LOG_SLOTS + 1;
  localparam int SLOTS = 1 << LOG_SLOTS;
  localparam logic [CNT_W-1:0] SLOT_COUNT = {1'b1, {LOG_SLOTS{1'b0}}};

  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  entry_t mem [SLOTS];
  entry_t rd_data_r;
  entry_t wr_data;
  logic [LOG_SLOTS-1:0] wr_addr;
  logic                 wr_en;

  logic                 mode_r;
  logic [PAGE_W-1:0]    page_r;
  logic [FRAME_W-1:0]   frame_r;
  logic [HASH_W-1:0]    prod_r;
  logic [LOG_SLOTS-1:0] idx_r;
  logic [LOG_SLOTS-1:0] probe_cnt_r;
  logic [LOG_SLOTS-1:0] clr_addr_r;
  logic [CNT_W-1:0]     count_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic [OCC_W-1:0]     out_occ_r;

  // item capture and multiplicative hash
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r  <= in_mode;
      page_r  <= in_page;
      frame_r <= in_frame;
      prod_r  <= HASH_W'(HASH_W'(in_page) * HASH_MULT);
    end
  end

  // probe walk
  always_ff @(posedge clk) begin
    if (cmd.load_home) begin
      idx_r       <= prod_r[HASH_W-1 -: LOG_SLOTS];
      probe_cnt_r <= '0;
    end else if (cmd.probe_next) begin
      idx_r       <= idx_r + 1'b1;
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_comb begin
    wr_en   = cmd.clr_wr | cmd.ins_wr;
    wr_addr = cmd.clr_wr ? clr_addr_r : idx_r;
    wr_data = cmd.clr_wr ? entry_t'('0) :
                           entry_t'{valid: 1'b1, page: page_r, frame: frame_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.ins_wr && count_r != SLOT_COUNT) begin
      count_r <= count_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_frame_r  <= (cmd.res_status == ST_HIT) ? rd_data_r.frame : '0;
      out_occ_r    <= OCC_W'(count_r);
    end
  end

  always_comb begin
    sts.is_insert  = (mode_r == MODE_INSERT);
    sts.slot_valid = rd_data_r.valid;
    sts.page_match = (rd_data_r.page == page_r);
    sts.last_probe = (probe_cnt_r == {LOG_SLOTS{1'b1}});
    sts.table_full = (count_r == SLOT_COUNT);
    sts.clr_done   = (clr_addr_r == {LOG_SLOTS{1'b1}});
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_frame  = out_frame_r;
  assign out_occ    = out_occ_r;

endmodule
`default_nettype wire

// ----- sv/ptht_ctrl.sv -----
// controller: clearing sweep, probe sequencing and result hand-off
`default_nettype none
module ptht_ctrl
  import ptht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ptht_sts_t sts,
  output ptht_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_st_r, res_st_nxt;

  always_comb begin
    state_nxt  = state_r;
    res_st_nxt = res_st_r;
    cmd        = '0;
    cmd.res_status = res_st_r;
    in_ready   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_HASH;
        end
      end
      S_HASH: begin
        cmd.load_home = 1'b1;
        if (sts.is_insert && sts.table_full) begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.slot_valid) begin
          cmd.ins_wr = sts.is_insert;
          res_st_nxt = sts.is_insert ? ST_INSERTED : ST_MISS;
          state_nxt  = S_RESP;
        end else if (!sts.is_insert && sts.page_match) begin
          res_st_nxt = ST_HIT;
          state_nxt  = S_RESP;
        end else if (sts.last_probe) begin
          res_st_nxt = sts.is_insert ? ST_FULL : ST_MISS;
          state_nxt  = S_RESP;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_READ;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      res_st_r <= ST_MISS;
    end else begin
      state_r  <= state_nxt;
      res_st_r <= res_st_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/page_translation_hash_table.sv -----
// after acceptance: a hash state, then a read and a check state per probed slot,
// then the result state, which waits until the result register is free
// a new item is taken only in the idle state, after the last result is loaded
// an insert into a full table skips the walk and goes straight to the result state
// reset is synchronous active low; a clearing sweep over all 2^LOG_SLOTS slots
// (256 by default) then empties the table before the first item is taken
`default_nettype none
module page_translation_hash_table
  import ptht_pkg::*;
#(
  parameter int LOG_SLOTS = LOG_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // page_number[19:0], frame_in[39:20]
  input  wire logic [0:0]  in_tuser,   // mode[0]
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // frame_out[19:0], occupancy[28:20], zero[31:29]
  output logic [1:0]       out_tuser   // status[1:0]
);

  ptht_cmd_t          cmd;
  ptht_sts_t          sts;
  status_t            res_status;
  logic [FRAME_W-1:0] res_frame;
  logic [OCC_W-1:0]   res_occ;

  // sequencer: sweep, walk and result hand-off
  ptht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot memory, hash and counters
  ptht_dpath #(
    .LOG_SLOTS (LOG_SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_tuser[0]),
    .in_page    (in_tdata[PAGE_W-1:0]),
    .in_frame   (in_tdata[PAGE_W +: FRAME_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_frame  (res_frame),
    .out_occ    (res_occ)
  );

  // pack the result item
  assign out_tdata = {3'b000, res_occ, res_frame};
  assign out_tuser = res_status;

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking testbench for the page translation hash table
`default_nettype none
module tb_top;
  import ptht_pkg::*;

  localparam int LOG_SLOTS    = LOG_SLOTS_DEF;
  localparam int SLOTS        = 1 << LOG_SLOTS;
  localparam int PHASE_ITEMS  = 580;
  // longest item: a full-table lookup miss, which walks every slot
  localparam int DRAIN_CYCLES = 4 * SLOTS;
  // about 1750 items, each at worst such a full walk, plus stalls, several times over
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_N        = 20;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] frame;
    logic [OCC_W-1:0]   occupancy;
  } xlate_result_t;

  typedef struct packed {
    logic               mode;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic               typed;   // result below is checked as written
    xlate_result_t      result;
  } dir_row_t;

  localparam xlate_result_t NO_TYPED = '{ST_MISS, 20'h0, 9'd0};

  // directed rows: empty table, field extremes, duplicates, wraparound at the top slot
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{MODE_LOOKUP, 20'h00000, 20'hFFFFF, 1'b1, '{ST_MISS,     20'h00000, 9'd0}},
    '{MODE_INSERT, 20'h00000, 20'hFFFFF, 1'b1, '{ST_INSERTED, 20'h00000, 9'd1}},
    '{MODE_LOOKUP, 20'h00000, 20'h00000, 1'b1, '{ST_HIT,      20'hFFFFF, 9'd1}},
    '{MODE_INSERT, 20'hFFFFF, 20'h00000, 1'b1, '{ST_INSERTED, 20'h00000, 9'd2}},
    '{MODE_LOOKUP, 20'hFFFFF, 20'hFFFFF, 1'b1, '{ST_HIT,      20'h00000, 9'd2}},
    // duplicate page: the first entry on the walk wins
    '{MODE_INSERT, 20'h00000, 20'h12345, 1'b1, '{ST_INSERTED, 20'h00000, 9'd3}},
    '{MODE_LOOKUP, 20'h00000, 20'h00000, 1'b1, '{ST_HIT,      20'hFFFFF, 9'd3}},
    // page fffff hashes near the top, repeated inserts wrap to slot 0 and beyond
    '{MODE_INSERT, 20'hFFFFF, 20'hAAAAA, 1'b1, '{ST_INSERTED, 20'h00000, 9'd4}},
    '{MODE_INSERT, 20'hFFFFF, 20'h55555, 1'b1, '{ST_INSERTED, 20'h00000, 9'd5}},
    '{MODE_INSERT, 20'hFFFFF, 20'h0F0F0, 1'b1, '{ST_INSERTED, 20'h00000, 9'd6}},
    '{MODE_INSERT, 20'hFFFFF, 20'hFFFFF, 1'b1, '{ST_INSERTED, 20'h00000, 9'd7}},
    '{MODE_LOOKUP, 20'hFFFFF, 20'h00000, 1'b1, '{ST_HIT,      20'h00000, 9'd7}},
    '{MODE_LOOKUP, 20'h00001, 20'h00000, 1'b0, NO_TYPED},
    '{MODE_LOOKUP, 20'h80000, 20'h7FFFF, 1'b0, NO_TYPED},
    '{MODE_INSERT, 20'h7FFFF, 20'h80000, 1'b0, NO_TYPED},
    '{MODE_LOOKUP, 20'h7FFFF, 20'h00000, 1'b0, NO_TYPED},
    '{MODE_LOOKUP, 20'h12345, 20'hFFFFF, 1'b0, NO_TYPED},
    '{MODE_INSERT, 20'h55555, 20'hAAAAA, 1'b0, NO_TYPED},
    '{MODE_LOOKUP, 20'h55555, 20'h00000, 1'b0, NO_TYPED},
    '{MODE_LOOKUP, 20'hAAAAA, 20'h55555, 1'b0, NO_TYPED}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;    // page_number[19:0], frame_in[39:20]
  logic [0:0]  in_tuser   = '0;    // mode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // frame_out[19:0], occupancy[28:20], zero[31:29]
  logic [1:0]  out_tuser;          // status[1:0]

  // shadow copy of the table
  bit                 slot_used [SLOTS];
  logic [PAGE_W-1:0]  slot_vpn  [SLOTS];
  logic [FRAME_W-1:0] slot_pfn  [SLOTS];
  int unsigned        used_count = 0;

  xlate_result_t      pending_results [$];
  logic [PAGE_W-1:0]  known_pages [$];
  xlate_result_t      predicted;
  xlate_result_t      oldest;
  xlate_result_t      row_result = NO_TYPED;
  logic               row_typed  = 1'b0;
  int                 fault_cnt  = 0;
  int                 src_gap_pct  = 0;
  int                 sink_gap_pct = 0;
  int unsigned        cycle_cnt  = 0;

  page_translation_hash_table #(
    .LOG_SLOTS (LOG_SLOTS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // walks the probe sequence of one item and updates the shadow table
  function automatic xlate_result_t translate(input logic mode, input logic [PAGE_W-1:0] vpn,
                                              input logic [FRAME_W-1:0] pfn);
    logic [HASH_W-1:0] prod;
    int unsigned       home;
    int unsigned       idx;
    int                i;
    xlate_result_t     res;
    prod = vpn * HASH_MULT;
    home = 32'(prod[HASH_W-1 -: LOG_SLOTS]);
    res.status = (mode == MODE_INSERT) ? ST_FULL : ST_MISS;
    res.frame  = '0;
    for (i = 0; i < SLOTS; i++) begin
      idx = (home + i) % SLOTS;
      if (mode == MODE_INSERT) begin
        if (!slot_used[idx]) begin
          slot_used[idx] = 1'b1;
          slot_vpn[idx]  = vpn;
          slot_pfn[idx]  = pfn;
          used_count++;
          res.status = ST_INSERTED;
          break;
        end
      end else begin
        // an empty slot ends the walk, a full table is walked once
        if (!slot_used[idx]) break;
        if (slot_vpn[idx] == vpn) begin
          res.status = ST_HIT;
          res.frame  = slot_pfn[idx];
          break;
        end
      end
    end
    res.occupancy = used_count[OCC_W-1:0];
    return res;
  endfunction

  // sender side, entered and left at a falling edge
  task automatic drive_item(input logic mode, input logic [PAGE_W-1:0] vpn,
                            input logic [FRAME_W-1:0] pfn, input logic typed,
                            input xlate_result_t typed_res);
    while ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {pfn, vpn};
    in_tuser   <= mode;
    row_typed  = typed;
    row_result = typed_res;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // sender holds off until every outstanding result is back
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_gap_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predicted = translate(in_tuser[0], in_tdata[PAGE_W-1:0], in_tdata[39:PAGE_W]);
        pending_results.push_back(row_typed ? row_result : predicted);
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= MAX_REPORTS)
            $display("unexpected result: status %0d tdata %h", out_tuser, out_tdata);
        end else begin
          oldest = pending_results.pop_front();
          if (out_tuser !== oldest.status ||
              out_tdata[FRAME_W-1:0] !== oldest.frame ||
              out_tdata[FRAME_W+OCC_W-1:FRAME_W] !== oldest.occupancy ||
              out_tdata[31:FRAME_W+OCC_W] !== '0) begin
            fault_cnt++;
            if (fault_cnt <= MAX_REPORTS)
              $display("mismatch: expected status %0d frame %h occ %0d, got status %0d frame %h occ %0d pad %b",
                       oldest.status, oldest.frame, oldest.occupancy, out_tuser,
                       out_tdata[FRAME_W-1:0], out_tdata[FRAME_W+OCC_W-1:FRAME_W],
                       out_tdata[31:FRAME_W+OCC_W]);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int                 n;
    int                 phase;
    int                 ins_pct;
    logic               mode;
    logic [PAGE_W-1:0]  vpn;
    logic [FRAME_W-1:0] pfn;
    logic [31:0]        rnd;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_gap_pct  = 6;
    sink_gap_pct = 73;
    for (n = 0; n < DIR_N; n++) begin
      drive_item(DIR_ROWS[n].mode, DIR_ROWS[n].page, DIR_ROWS[n].frame,
                 DIR_ROWS[n].typed, DIR_ROWS[n].result);
    end
    hold_until_drained();

    // light load first, then a heavier insert mix that fills the table
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_gap_pct = 6;  sink_gap_pct = 73; ins_pct = 12;
        end
        1: begin
          src_gap_pct = 73; sink_gap_pct = 6;  ins_pct = 12;
        end
        default: begin
          src_gap_pct = 0;  sink_gap_pct = 0;  ins_pct = 33;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        rnd  = $urandom();
        mode = ($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_LOOKUP;
        if (mode == MODE_INSERT) begin
          // some inserts repeat a known page to build duplicates
          if (known_pages.size() != 0 && $urandom_range(99) < 20)
            vpn = known_pages[$urandom_range(known_pages.size() - 1)];
          else
            vpn = rnd[PAGE_W-1:0];
          known_pages.push_back(vpn);
        end else begin
          if (known_pages.size() != 0 && $urandom_range(99) < 65)
            vpn = known_pages[$urandom_range(known_pages.size() - 1)];
          else
            vpn = rnd[PAGE_W-1:0];
        end
        rnd = $urandom();
        pfn = rnd[FRAME_W-1:0];
        drive_item(mode, vpn, pfn, 1'b0, NO_TYPED);
      end
      hold_until_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_cnt == 0 && pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
